>>> design/frm_pkg.sv
`timescale 1ns / 1ps
// Package for the framed RMS meter: sizes, register indexes, sequencer states.
// No dependencies.
package frm_pkg;
  localparam int MaxChannels = 8;
  localparam int MaxWindow   = 4096;
  localparam int ChW   = $clog2(MaxChannels);
  localparam int WinW  = $clog2(MaxWindow);
  localparam int CntW  = WinW + 1;
  localparam int SumW  = 32 + WinW - 1;
  localparam int RingAw = ChW + WinW;

  localparam logic [1:0] RegChannels = 2'd0;
  localparam logic [1:0] RegWindow   = 2'd1;
  localparam logic [1:0] RegHop      = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_SQ_OLD, S_SUB, S_SQ_NEW, S_ADD, S_FRAME,
    S_DIV_INIT, S_DIV, S_SQRT, S_OUT
  } state_t;
endpackage

>>> design/frm_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface carrying a payload of type T.
// Depends on nothing.
interface frm_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/framed_rms_meter.sv
`timescale 1ns / 1ps
// Framed RMS meter top level: sequencer, ring memory, shared arithmetic unit.
// Depends on frm_pkg and frm_stream_if.
//
// Usage: in_ch carries one interleaved Q1.15 sample per item {sample, end_of_track}.
// out_ch carries results {channel, frame_number, rms_value, whole_track, run_end}.
// Registers on the APB port: channel_count at 0x0, window_length at 0x4, hop_size
// at 0x8; a write restarts the track. Write only while the block is idle.
// Each item passes through accept, ring read, old square, subtract, new square,
// add and frame update on one shared multiplier and adder. When a sample frame ends on
// a window or hop boundary, or at a short track's end, one result per channel
// follows, each produced by a shift-subtract divider (after a setup step)
// and a digit-by-digit square root (after a load step) on the same adder.
// in ready is low until all results have been taken; each result waits in
// the output register while the receiver stalls. Old ring samples are used only at slots
// written in the current track, so the ring needs no clearing pass. Reset clears
// all track state and sets registers to 1, 2048, 512.
module framed_rms_meter
  import frm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  frm_stream_if.sink   in_ch,
  frm_stream_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [3:0]  nch_reg_r;
  logic [12:0] win_reg_r, hop_reg_r;
  logic [ChW:0] nch;
  logic [CntW-1:0] win, hop;
  state_t state_r, state_nxt;

  logic [SumW-1:0] sums_r [MaxChannels];
  logic [15:0] ring [1 << RingAw];
  logic [15:0] ring_q_r;
  logic [ChW-1:0] cpos_r, ch_r;
  logic [CntW-1:0] fill_r, hop_cnt_r;
  logic [WinW-1:0] rptr_r, slot_r;
  logic [31:0] frames_r;
  logic [15:0] samp_r;
  logic end_r, emit_r, whole_r;
  logic [31:0] sq_r;
  logic [SumW-1:0] rem_r, quo_r, sres_r, sbit_r;
  logic [CntW-1:0] div_r;
  logic [5:0] it_r;
  logic [15:0] rms_r;
  logic out_valid_r;
  logic cfg_wr, in_acc, out_acc;
  logic [CntW-1:0] fill_inc;
  logic frame_last, fr_emit, fr_whole;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = {ch_r, emit_r ? frames_r : 32'd0, rms_r, whole_r,
                        ({1'b0, ch_r} + 4'd1) == nch};

  always_comb begin
    nch = (nch_reg_r == 4'd0) ? 4'd1 : (nch_reg_r > 4'(MaxChannels)) ?
          4'(MaxChannels) : nch_reg_r;
    win = (win_reg_r == 13'd0) ? 13'd1 : (win_reg_r > 13'(MaxWindow)) ?
          13'(MaxWindow) : win_reg_r;
    hop = (hop_reg_r == 13'd0) ? 13'd1 : (hop_reg_r > 13'(MaxWindow)) ?
          13'(MaxWindow) : hop_reg_r;
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      RegChannels: cfg_prdata = {28'd0, nch_reg_r};
      RegWindow:   cfg_prdata = {19'd0, win_reg_r};
      RegHop:      cfg_prdata = {19'd0, hop_reg_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // shared multiplier operand: magnitude of a sample
  logic [15:0] mag_in, mag;
  logic [SumW-1:0] add_a, add_b, add_y;
  logic add_sub;
  always_comb begin
    mag_in = (state_r == S_SQ_OLD) ? ring_q_r : samp_r;
    mag = mag_in[15] ? 16'(-mag_in) : mag_in;
    add_a = sums_r[ch_r];
    add_b = SumW'(sq_r);
    add_sub = 1'b0;
    unique case (state_r)
      S_SUB: add_sub = 1'b1;
      S_DIV: begin
        add_a = {rem_r[SumW-2:0], quo_r[SumW-1]};
        add_b = SumW'(div_r);
        add_sub = 1'b1;
      end
      S_SQRT: begin
        add_a = rem_r;
        add_b = sres_r + sbit_r;
        add_sub = 1'b1;
      end
      default: ;
    endcase
    add_y = add_sub ? add_a - add_b : add_a + add_b;
  end

  logic div_ok, sqrt_ok;
  assign div_ok = {rem_r[SumW-2:0], quo_r[SumW-1]} >= SumW'(div_r);
  assign sqrt_ok = rem_r >= sres_r + sbit_r;

  // frame decision for the sample just added
  assign fill_inc = fill_r + 1'b1;
  assign frame_last = ({1'b0, ch_r} + 4'd1) >= nch;
  assign fr_emit = frame_last && ((fill_r < win) ? (fill_inc == win) : (hop_cnt_r == '0));
  assign fr_whole = frame_last && end_r && (fill_r < win) && (fill_inc != win);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_READ;
      S_READ:   state_nxt = S_SQ_OLD;
      S_SQ_OLD: state_nxt = S_SUB;
      S_SUB:    state_nxt = S_SQ_NEW;
      S_SQ_NEW: state_nxt = S_ADD;
      S_ADD:    state_nxt = S_FRAME;
      S_FRAME:  state_nxt = (fr_emit || fr_whole) ? S_DIV_INIT : S_IDLE;
      S_DIV_INIT: state_nxt = S_DIV;
      S_DIV:    if (it_r == 6'd0) state_nxt = S_SQRT;
      S_SQRT:   if (sbit_r[1:0] != 2'd0) state_nxt = S_OUT;
      S_OUT:    if (out_acc) state_nxt = (({1'b0, ch_r} + 4'd1) == nch) ?
                  S_IDLE : S_DIV_INIT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) ring_q_r <= ring[{cpos_r, slot_r}];
    if (state_r == S_ADD) ring[{ch_r, slot_r}] <= samp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nch_reg_r <= 4'd1;
      win_reg_r <= 13'd2048;
      hop_reg_r <= 13'd512;
      out_valid_r <= 1'b0;
      cpos_r <= '0; fill_r <= '0; hop_cnt_r <= '0; rptr_r <= '0; frames_r <= '0;
      for (int i = 0; i < MaxChannels; i++) sums_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          RegChannels: nch_reg_r <= cfg_pwdata[3:0];
          RegWindow:   win_reg_r <= cfg_pwdata[12:0];
          RegHop:      hop_reg_r <= cfg_pwdata[12:0];
          default: ;
        endcase
        if (cfg_paddr[3:2] <= RegHop) begin
          cpos_r <= '0; fill_r <= '0; hop_cnt_r <= '0; rptr_r <= '0;
          frames_r <= '0;
          for (int i = 0; i < MaxChannels; i++) sums_r[i] <= '0;
        end
      end
      unique case (state_r)
        S_IDLE: if (in_acc) begin
          samp_r <= in_ch.data[16:1];
          end_r <= in_ch.data[0];
          if ({1'b0, cpos_r} >= nch) cpos_r <= '0;
          ch_r <= ({1'b0, cpos_r} >= nch) ? '0 : cpos_r;
          slot_r <= ({1'b0, rptr_r} < win) ? rptr_r : '0;
        end
        S_READ: ;
        S_SQ_OLD: sq_r <= mag * mag;
        S_SUB: if (fill_r >= win) sums_r[ch_r] <= add_y;
        S_SQ_NEW: sq_r <= mag * mag;
        S_ADD: sums_r[ch_r] <= add_y;
        S_FRAME: begin
          emit_r <= fr_emit;
          whole_r <= fr_whole;
          if (!frame_last) begin
            cpos_r <= ch_r + 1'b1;
          end else if (end_r && !fr_emit && !fr_whole) begin
            // end without results: restart now
            cpos_r <= '0; fill_r <= '0; hop_cnt_r <= '0; rptr_r <= '0; frames_r <= '0;
            for (int i = 0; i < MaxChannels; i++) sums_r[i] <= '0;
          end else begin
            cpos_r <= '0;
            rptr_r <= ({1'b0, slot_r} + 1'b1 >= win) ? '0 : slot_r + 1'b1;
            ch_r <= '0;
            if (fill_r < win) fill_r <= fill_inc;
            if (fr_emit) hop_cnt_r <= hop - 1'b1;
            else if (fill_r >= win) hop_cnt_r <= hop_cnt_r - 1'b1;
            div_r <= fr_emit ? win : fill_inc;
          end
        end
        S_DIV_INIT: begin
          rem_r <= '0; quo_r <= sums_r[ch_r]; it_r <= 6'(SumW - 1);
        end
        S_DIV: begin
          rem_r <= div_ok ? add_y : {rem_r[SumW-2:0], quo_r[SumW-1]};
          quo_r <= {quo_r[SumW-2:0], div_ok};
          it_r <= it_r - 1'b1;
          if (it_r == 6'd0) begin
            sres_r <= '0;
            sbit_r <= SumW'(1) << (SumW - 2 + (SumW % 2));
          end
        end
        S_SQRT: begin
          if (it_r == 6'd63) begin
            rem_r <= quo_r; it_r <= 6'd62;
          end else begin
            if (sqrt_ok) begin
              rem_r <= add_y; sres_r <= (sres_r >> 1) + sbit_r;
            end else sres_r <= sres_r >> 1;
            sbit_r <= sbit_r >> 2;
            if (sbit_r[1:0] != 2'd0) begin
              rms_r <= sqrt_ok ? 16'((sres_r >> 1) + sbit_r) : 16'(sres_r >> 1);
              out_valid_r <= 1'b1;
            end
          end
        end
        S_OUT: if (out_acc) begin
          out_valid_r <= 1'b0;
          if (({1'b0, ch_r} + 4'd1) == nch) begin
            if (end_r) begin
              fill_r <= '0; hop_cnt_r <= '0; rptr_r <= '0; frames_r <= '0;
              for (int i = 0; i < MaxChannels; i++) sums_r[i] <= '0;
            end else if (emit_r) begin
              frames_r <= frames_r + 1'b1;
            end
          end else ch_r <= ch_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(rms_r))
    else $error("result dropped");
  a_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ({1'b0, ch_r} < nch)) else $error("channel out of range");
endmodule

>>> verif/framed_rms_meter_test.sv
`timescale 1ns / 1ps
// Testbench for framed_rms_meter: interleaved samples in, per-channel framed RMS out.
// A built-in predictor checks every result field. Depends on frm_pkg, frm_stream_if
// and the design.
module framed_rms_meter_test
  import frm_pkg::*;
();

  typedef struct packed {
    logic signed [15:0] sample;
    logic               end_of_track;
  } rms_in_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [31:0] frame_number;
    logic [15:0] rms_value;
    logic        whole_track;
    logic        run_end;
  } rms_out_t;

  localparam int StallLimit = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frm_stream_if #(.T(rms_in_t))  in_ch ();
  frm_stream_if #(.T(rms_out_t)) out_ch ();

  framed_rms_meter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [3:0]   chan_reg;
  logic [12:0]  win_reg, hop_reg;
  logic [15:0]  history [MaxChannels][MaxWindow];
  logic [63:0]  energy [MaxChannels];
  int unsigned  next_chan, frames_filled, hop_left, oldest_slot;
  logic [31:0]  emitted_frames;

  rms_out_t     rms_expected [$];
  int           errors = 0;
  int           burst_left = 0;
  int           hold_cycles = 0;
  int           idle_count = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [63:0] square16(logic [15:0] raw);
    logic signed [16:0] v;
    logic [16:0]        m;
    v = $signed(raw);
    m = (v < 0) ? -v : v;
    return 64'(m) * 64'(m);
  endfunction

  function automatic logic [31:0] root64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[31:0];
  endfunction

  function automatic void restart_track();
    for (int i = 0; i < MaxChannels; i++) energy[i] = 0;
    next_chan = 0;
    frames_filled = 0;
    hop_left = 0;
    oldest_slot = 0;
    emitted_frames = 0;
  endfunction

  // Work out the results one accepted sample causes and queue them.
  function automatic void predict_rms(rms_in_t it);
    int unsigned nch, win, hop, c, slot, div;
    bit          emit, whole;
    rms_out_t    r;
    logic [31:0] rt;
    nch = clamp_reg(chan_reg, MaxChannels);
    win = clamp_reg(win_reg, MaxWindow);
    hop = clamp_reg(hop_reg, MaxWindow);
    emit = 0;
    whole = 0;
    c = (next_chan >= nch) ? 0 : next_chan;
    slot = (oldest_slot < win) ? oldest_slot : 0;
    if (frames_filled >= win) energy[c] -= square16(history[c][slot]);
    energy[c] += square16(it.sample);
    history[c][slot] = it.sample;
    if (c + 1 < nch) begin
      next_chan = c + 1;
      return;
    end
    next_chan = 0;
    oldest_slot = (slot + 1 >= win) ? 0 : slot + 1;
    if (frames_filled < win) begin
      frames_filled++;
      if (frames_filled == win) begin
        emit = 1;
        hop_left = hop - 1;
      end
    end else if (hop_left == 0) begin
      emit = 1;
      hop_left = hop - 1;
    end else begin
      hop_left--;
    end
    if (!emit && it.end_of_track && frames_filled < win && frames_filled > 0) whole = 1;
    if (emit || whole) begin
      div = emit ? win : frames_filled;
      for (int unsigned ch = 0; ch < nch; ch++) begin
        r.channel = ch[2:0];
        r.frame_number = emit ? emitted_frames : 32'd0;
        rt = root64(energy[ch] / div);
        r.rms_value = rt[15:0];
        r.whole_track = whole;
        r.run_end = (ch + 1 == nch);
        rms_expected = {rms_expected, r};
      end
      if (emit) emitted_frames++;
    end
    if (it.end_of_track) restart_track();
  endfunction

  // Sender: bursts of random length separated by random gaps.
  task automatic send_sample(logic signed [15:0] s, logic eot);
    rms_in_t it;
    int      gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    it.sample = s;
    it.end_of_track = eot;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    predict_rms(it);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (rms_expected.size() != 0) @(posedge clk);
    // the block may still be busy on an item that caused no result
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      RegChannels: chan_reg = value[3:0];
      RegWindow:   win_reg = value[12:0];
      RegHop:      hop_reg = value[12:0];
      default: ;
    endcase
    restart_track();
  endtask

  task automatic configure(int unsigned nch, int unsigned win, int unsigned hop);
    write_reg(RegChannels, nch);
    write_reg(RegWindow, win);
    write_reg(RegHop, hop);
  endtask

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Reset values: one channel, long window, so a short track yields whole-track RMS.
  task automatic test_reset_defaults();
    send_sample(16'sh4000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh1234, 1'b1);
  endtask

  task automatic test_directed_cases();
    configure(2, 3, 2);
    // end mark on channel 0 is ignored
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shffff, 1'b0);   // window fills
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b1);   // ends on a hop boundary
    for (int i = 0; i < 8; i++)
      send_sample(16'sh5555 ^ 16'(i), i == 7);  // ends off the hop boundary
    // short track ending after one frame
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
  endtask

  task automatic test_register_extremes();
    configure(0, 0, 0);     // all act as 1
    for (int i = 0; i < 4; i++) send_sample(pick_sample(), i == 3);
    configure(15, 8191, 8191);  // saturate to 8 channels, 4096 window and hop
    for (int i = 0; i < 16; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7fff, i == 15);
    configure(8, 1, 4096);
    for (int i = 0; i < 24; i++) send_sample(pick_sample(), 1'b0);
    configure(1, 4096, 1);
    for (int i = 0; i < 5; i++) send_sample(pick_sample(), i == 4);
  endtask

  task automatic test_random_tracks();
    int unsigned nch, win, hop, frames, sent;
    bit          cut;
    sent = 0;
    for (int k = 0; k < 7; k++) begin
      nch = $urandom_range(1, 8);
      win = $urandom_range(1, 8);
      hop = $urandom_range(1, 4);
      configure(nch, win, hop);
      if (k == 2) hold_cycles = 500;   // receiver holds off while items keep coming
      while (sent < 55 * (k + 1)) begin
        frames = $urandom_range(1, win + 3 * hop + 2);
        cut = ($urandom_range(0, 9) == 0);
        for (int unsigned f = 0; f < frames; f++)
          for (int unsigned c = 0; c < nch; c++) begin
            send_sample(pick_sample(),
                        (f == frames - 1 && c == nch - 1 && !cut) ||
                        ($urandom_range(0, 15) == 0));
            sent++;
          end
        if (k == 4) wait_drained();
      end
    end
  endtask

  // Result checker and stall pattern.
  int stall_mode = 0;
  int stall_phase = 0;
  always @(posedge clk) begin
    rms_out_t got, want;
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (rms_expected.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = rms_expected.pop_front();
        if (got.channel !== want.channel) begin
          $display("%0t: channel expected %0d actual %0d", $time, want.channel, got.channel);
          errors++;
        end
        if (got.frame_number !== want.frame_number) begin
          $display("%0t: frame_number expected %0d actual %0d", $time,
                   want.frame_number, got.frame_number);
          errors++;
        end
        if (got.rms_value !== want.rms_value) begin
          $display("%0t: rms_value expected %0d actual %0d", $time,
                   want.rms_value, got.rms_value);
          errors++;
        end
        if (got.whole_track !== want.whole_track) begin
          $display("%0t: whole_track expected %0b actual %0b", $time,
                   want.whole_track, got.whole_track);
          errors++;
        end
        if (got.run_end !== want.run_end) begin
          $display("%0t: run_end expected %0b actual %0b", $time, want.run_end, got.run_end);
          errors++;
        end
      end
    end
    if (stall_phase == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_phase = $urandom_range(20, 150);
    end else begin
      stall_phase--;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog: count cycles with no item moving on any port.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    chan_reg = 1;
    win_reg = 2048;
    hop_reg = 512;
    restart_track();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_cases();
    test_register_extremes();
    test_random_tracks();
    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

>>> sim.f
design/frm_pkg.sv
design/frm_stream_if.sv
design/framed_rms_meter.sv
verif/framed_rms_meter_test.sv
